// ----- rtl/core/sawfr_pkg.sv -----
// Shared types and constants for the stop-and-wait frame receiver.
// Depends on nothing; every other file of the block uses it.
package sawfr_pkg;

   // Frame header and stuffing bytes.
   localparam logic [7:0] FLAG_BYTE      = 8'h7E;
   localparam logic [7:0] ESC_BYTE       = 8'h7D;
   localparam logic [7:0] ESC_FLAG_BYTE  = 8'h5E;
   localparam logic [7:0] ESC_ESC_BYTE   = 8'h5D;
   localparam logic [7:0] ADDR_BYTE      = 8'h03;
   localparam logic [7:0] CTRL_DATA_BYTE = 8'h01;
   localparam logic [7:0] CTRL_DISC_BYTE = 8'h0B;
   localparam logic [7:0] BCC1_BYTE      = 8'h02;

   // Response control bytes.
   localparam logic [7:0] RR0_BYTE  = 8'hAA;
   localparam logic [7:0] RR1_BYTE  = 8'hAB;
   localparam logic [7:0] REJ0_BYTE = 8'h54;
   localparam logic [7:0] REJ1_BYTE = 8'h55;

   localparam int unsigned MAX_PAYLOAD = 1024;
   localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);

   localparam logic [7:0] MAX_ATTEMPTS_RESET = 8'd5;

   typedef enum logic [0:0] {
      REQ_BYTE    = 1'b0,
      REQ_TIMEOUT = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      KIND_PAYLOAD       = 3'd0,
      KIND_ACCEPTED      = 3'd1,
      KIND_REJECTED      = 3'd2,
      KIND_REJECTED_LAST = 3'd3,
      KIND_TIMEOUT       = 3'd4,
      KIND_TIMEOUT_LAST  = 3'd5,
      KIND_DISCONNECT    = 3'd6
   } out_kind_type;

   typedef enum logic [5:0] {
      HS_FLAG  = 6'b000001,
      HS_ADDR  = 6'b000010,
      HS_CTRL  = 6'b000100,
      HS_BCC1  = 6'b001000,
      HS_FIRST = 6'b010000,
      HS_DATA  = 6'b100000
   } hunt_state_type;

   typedef struct packed {
      hunt_state_type   hunt;
      logic             escape_seen;
      logic             held_valid;
      logic [7:0]       held_byte;
      logic [7:0]       running_xor;
      logic             sequence_bit;
      logic [7:0]       attempts_left;
      logic [LEN_W-1:0] byte_count;
   } frame_state_type;

   typedef struct packed {
      logic             valid;
      out_kind_type     kind;
      logic [7:0]       data;
      logic [7:0]       ctrl;
      logic [LEN_W-1:0] length;
   } result_type;

endpackage

// ----- rtl/core/sawfr_ifs.sv -----
// Valid/ready channel interfaces of the stop-and-wait frame receiver.
// Depends on sawfr_pkg for field widths and codes.
interface sawfr_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] rx_byte;
   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface sawfr_rsp_if;
   logic                           valid;
   logic                           ready;
   sawfr_pkg::out_kind_type        out_kind;
   logic [7:0]                     data_byte;
   logic [7:0]                     response_ctrl;
   logic [sawfr_pkg::LEN_W-1:0]    payload_length;
   modport source (output valid, output out_kind, output data_byte,
                   output response_ctrl, output payload_length, input ready);
   modport sink   (input valid, input out_kind, input data_byte,
                   input response_ctrl, input payload_length, output ready);
endinterface

interface sawfr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] max_attempts;
   modport source (output valid, output max_attempts, input ready);
   modport sink   (input valid, input max_attempts, output ready);
endinterface

// ----- rtl/core/sawfr_step.sv -----
// Next-state and result logic for one transaction of the frame receiver.
// Purely combinational; depends on sawfr_pkg.
module sawfr_step (
   input  sawfr_pkg::frame_state_type state_cur,
   input  logic [7:0]                 max_attempts,
   input  logic                       req_type,
   input  logic [7:0]                 rx_byte,
   output sawfr_pkg::frame_state_type state_nxt,
   output sawfr_pkg::result_type      result
);

   logic       att_last;
   logic [7:0] att_after;
   logic       take;
   logic [7:0] take_data;
   logic       esc_after;
   logic       close_ok;
   logic [7:0] rej_ctrl;
   logic [7:0] rr_ctrl;

   // Using up an attempt: the last one reloads the counter.
   assign att_last  = (state_cur.attempts_left <= 8'd1);
   assign att_after = att_last ? max_attempts : state_cur.attempts_left - 8'd1;

   // Destuffing of one data byte.
   always_comb begin
      take      = 1'b0;
      take_data = rx_byte;
      esc_after = 1'b0;
      if (state_cur.escape_seen) begin
         if (rx_byte == sawfr_pkg::ESC_FLAG_BYTE) begin
            take      = 1'b1;
            take_data = sawfr_pkg::FLAG_BYTE;
         end else if (rx_byte == sawfr_pkg::ESC_ESC_BYTE) begin
            take      = 1'b1;
            take_data = sawfr_pkg::ESC_BYTE;
         end
      end else if (rx_byte == sawfr_pkg::ESC_BYTE) begin
         esc_after = 1'b1;
      end else begin
         take = 1'b1;
      end
   end

   assign close_ok = state_cur.held_valid && (state_cur.held_byte == state_cur.running_xor);
   assign rr_ctrl  = state_cur.sequence_bit ? sawfr_pkg::RR1_BYTE : sawfr_pkg::RR0_BYTE;
   assign rej_ctrl = state_cur.sequence_bit ? sawfr_pkg::REJ1_BYTE : sawfr_pkg::REJ0_BYTE;

   always_comb begin
      state_nxt     = state_cur;
      result.valid  = 1'b0;
      result.kind   = sawfr_pkg::KIND_PAYLOAD;
      result.data   = 8'd0;
      result.ctrl   = 8'd0;
      result.length = '0;

      if (req_type == sawfr_pkg::REQ_TIMEOUT) begin
         result.valid            = 1'b1;
         result.kind             = att_last ? sawfr_pkg::KIND_TIMEOUT_LAST
                                            : sawfr_pkg::KIND_TIMEOUT;
         state_nxt.attempts_left = att_after;
         state_nxt.hunt          = sawfr_pkg::HS_FLAG;
         state_nxt.escape_seen   = 1'b0;
         state_nxt.held_valid    = 1'b0;
         state_nxt.held_byte     = 8'd0;
         state_nxt.running_xor   = 8'd0;
         state_nxt.byte_count    = '0;
      end else begin
         unique case (state_cur.hunt) inside
            sawfr_pkg::HS_FLAG: begin
               if (rx_byte == sawfr_pkg::FLAG_BYTE) state_nxt.hunt = sawfr_pkg::HS_ADDR;
            end
            sawfr_pkg::HS_ADDR: begin
               if (rx_byte == sawfr_pkg::ADDR_BYTE) state_nxt.hunt = sawfr_pkg::HS_CTRL;
            end
            sawfr_pkg::HS_CTRL: begin
               if (rx_byte == sawfr_pkg::CTRL_DATA_BYTE) begin
                  state_nxt.hunt = sawfr_pkg::HS_BCC1;
               end else if (rx_byte == sawfr_pkg::CTRL_DISC_BYTE) begin
                  result.valid            = 1'b1;
                  result.kind             = sawfr_pkg::KIND_DISCONNECT;
                  state_nxt.attempts_left = max_attempts;
                  state_nxt.hunt          = sawfr_pkg::HS_FLAG;
               end
            end
            sawfr_pkg::HS_BCC1: begin
               if (rx_byte == sawfr_pkg::BCC1_BYTE) state_nxt.hunt = sawfr_pkg::HS_FIRST;
            end
            sawfr_pkg::HS_FIRST, sawfr_pkg::HS_DATA: begin
               if (rx_byte == sawfr_pkg::FLAG_BYTE) begin
                  // A flag before any data is ignored; otherwise it closes the frame.
                  if (state_cur.hunt == sawfr_pkg::HS_DATA) begin
                     result.valid  = 1'b1;
                     result.length = state_cur.byte_count;
                     if (close_ok) begin
                        result.kind             = sawfr_pkg::KIND_ACCEPTED;
                        result.ctrl             = rr_ctrl;
                        state_nxt.sequence_bit  = ~state_cur.sequence_bit;
                        state_nxt.attempts_left = max_attempts;
                     end else begin
                        result.kind             = att_last ? sawfr_pkg::KIND_REJECTED_LAST
                                                           : sawfr_pkg::KIND_REJECTED;
                        result.ctrl             = rej_ctrl;
                        state_nxt.attempts_left = att_after;
                     end
                     state_nxt.hunt        = sawfr_pkg::HS_FLAG;
                     state_nxt.escape_seen = 1'b0;
                     state_nxt.held_valid  = 1'b0;
                     state_nxt.held_byte   = 8'd0;
                     state_nxt.running_xor = 8'd0;
                     state_nxt.byte_count  = '0;
                  end
               end else begin
                  state_nxt.hunt        = sawfr_pkg::HS_DATA;
                  state_nxt.escape_seen = esc_after;
                  if (take) begin
                     state_nxt.held_byte  = take_data;
                     state_nxt.held_valid = 1'b1;
                     if (state_cur.held_valid) begin
                        result.valid          = 1'b1;
                        result.kind           = sawfr_pkg::KIND_PAYLOAD;
                        result.data           = state_cur.held_byte;
                        state_nxt.running_xor = state_cur.running_xor ^ state_cur.held_byte;
                        if (state_cur.byte_count != sawfr_pkg::LEN_MAX) begin
                           state_nxt.byte_count = state_cur.byte_count + 1'b1;
                        end
                     end
                  end
               end
            end
            default: begin
               state_nxt.hunt        = sawfr_pkg::HS_FLAG;
               state_nxt.escape_seen = 1'b0;
               state_nxt.held_valid  = 1'b0;
               state_nxt.held_byte   = 8'd0;
               state_nxt.running_xor = 8'd0;
               state_nxt.byte_count  = '0;
            end
         endcase
      end
   end

endmodule

// ----- rtl/core/stop_and_wait_frame_receiver_core.sv -----
// Top level of the stop-and-wait frame receiver with byte destuffing and BCC2 check.
// Depends on sawfr_pkg, the channel interfaces in sawfr_ifs and sawfr_step.
//
//   Channel  Direction  Moves per transaction
//   req_bus  in         one received byte or one receive-timeout event
//   rsp_bus  out        one payload byte or one verdict (accept, reject, timeout, disconnect)
//   csr_bus  in         a new value of max_attempts
//
// Every accepted request is processed in the cycle it is accepted; its result, if any,
// is in the response register in the next cycle. One request per cycle is sustained while
// the consumer takes results. The response register is the only buffer: req_bus.ready is
// high whenever it is empty or drains this cycle, so a stalled consumer stalls the input.
// Reset is synchronous and active high; it clears the frame hunt, the sequence bit and
// reloads the attempt counter with 5.
module stop_and_wait_frame_receiver_core (
   input logic                clock,
   input logic                reset,
   sawfr_req_if.sink          req_bus,
   sawfr_rsp_if.source        rsp_bus,
   sawfr_csr_if.sink          csr_bus
);

   // Receiver state that persists between transactions.
   sawfr_pkg::frame_state_type state_ff;
   sawfr_pkg::frame_state_type state_in;
   sawfr_pkg::frame_state_type state_step;
   sawfr_pkg::result_type      step_result;

   logic [7:0] max_attempts_ff;
   logic [7:0] max_attempts_in;

   // Response register: valid is control state, the payload needs no reset.
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   sawfr_pkg::out_kind_type    rsp_kind_ff;
   sawfr_pkg::out_kind_type    rsp_kind_in;
   logic [7:0]                 rsp_data_ff;
   logic [7:0]                 rsp_data_in;
   logic [7:0]                 rsp_ctrl_ff;
   logic [7:0]                 rsp_ctrl_in;
   logic [sawfr_pkg::LEN_W-1:0] rsp_len_ff;
   logic [sawfr_pkg::LEN_W-1:0] rsp_len_in;

   logic req_fire;
   logic rsp_free;

   // The response slot can take a new result when it is empty or drains this cycle.
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = rsp_free;
   assign req_fire      = req_bus.valid && rsp_free;

   // Configuration is always accepted; the user must write it only while idle (not enforced).
   assign csr_bus.ready   = 1'b1;
   assign max_attempts_in = csr_bus.valid ? csr_bus.max_attempts : max_attempts_ff;

   sawfr_step u_step (
      .state_cur    (state_ff),
      .max_attempts (max_attempts_ff),
      .req_type     (req_bus.req_type),
      .rx_byte      (req_bus.rx_byte),
      .state_nxt    (state_step),
      .result       (step_result)
   );

   assign state_in = req_fire ? state_step : state_ff;

   // A new result replaces the slot; otherwise a taken result leaves it empty.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_ctrl_in  = rsp_ctrl_ff;
      rsp_len_in   = rsp_len_ff;
      if (req_fire && step_result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = step_result.kind;
         rsp_data_in  = step_result.data;
         rsp_ctrl_in  = step_result.ctrl;
         rsp_len_in   = step_result.length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.hunt          <= sawfr_pkg::HS_FLAG;
         state_ff.escape_seen   <= 1'b0;
         state_ff.held_valid    <= 1'b0;
         state_ff.held_byte     <= 8'd0;
         state_ff.running_xor   <= 8'd0;
         state_ff.sequence_bit  <= 1'b0;
         state_ff.attempts_left <= sawfr_pkg::MAX_ATTEMPTS_RESET;
         state_ff.byte_count    <= '0;
         max_attempts_ff        <= sawfr_pkg::MAX_ATTEMPTS_RESET;
         rsp_valid_ff           <= 1'b0;
      end else begin
         state_ff        <= state_in;
         max_attempts_ff <= max_attempts_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ctrl_ff <= rsp_ctrl_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.out_kind       = rsp_kind_ff;
   assign rsp_bus.data_byte      = rsp_data_ff;
   assign rsp_bus.response_ctrl  = rsp_ctrl_ff;
   assign rsp_bus.payload_length = rsp_len_ff;

`ifndef ASSERT_OFF
   // Input is only held off while a result waits on a stalled consumer.
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (rsp_valid_ff && !rsp_bus.ready))
      else $error("request stalled without a pending response");

   // An accept toggles the sequence bit and reloads the attempts.
   a_accept_toggles_seq: assert property (@(posedge clock) disable iff (reset)
      (req_fire && step_result.valid && step_result.kind == sawfr_pkg::KIND_ACCEPTED)
      |=> (state_ff.sequence_bit != $past(state_ff.sequence_bit))
          && (state_ff.attempts_left == $past(max_attempts_ff)))
      else $error("accept did not toggle the sequence bit or reload attempts");

   // The payload count saturates and never passes the maximum.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff.byte_count <= sawfr_pkg::LEN_MAX)
      else $error("payload count beyond maximum");

   // Payload bytes carry no control byte and no length.
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == sawfr_pkg::KIND_PAYLOAD)
      |-> (rsp_ctrl_ff == 8'd0 && rsp_len_ff == '0))
      else $error("payload byte with control or length set");

   // Outside a frame body no byte is held back.
   a_no_held_outside: assert property (@(posedge clock) disable iff (reset)
      (state_ff.hunt != sawfr_pkg::HS_DATA) |-> !state_ff.held_valid)
      else $error("held byte outside a frame body");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for stop_and_wait_frame_receiver_core.
// Depends on sawfr_pkg and the channel interfaces in sawfr_ifs; it contains a
// scoreboard class that predicts every result, and plain tasks that drive the block.
`timescale 1ns / 1ps

module tb;

   // The run is abandoned after this many clock cycles.
   localparam int unsigned CYCLE_LIMIT = 400000;

   // Scoreboard. It mirrors the frame hunt, destuffing, check byte and attempt
   // counting of the block. Each accepted request transaction is fed to
   // note_rx_item, which queues the result the block must produce, if any.
   // Each accepted response transaction is compared with the oldest queued one.
   class frame_verdict_board;
      typedef struct {
         sawfr_pkg::out_kind_type     kind;
         logic [7:0]                  data;
         logic [7:0]                  ctrl;
         logic [sawfr_pkg::LEN_W-1:0] length;
      } rsp_fields_type;

      rsp_fields_type              awaited_rsps[$];
      int unsigned                 failures;

      logic [7:0]                  max_attempts;
      sawfr_pkg::hunt_state_type   hunt;
      logic                        escape_seen;
      logic                        held_valid;
      logic [7:0]                  held_byte;
      logic [7:0]                  running_xor;
      logic                        sequence_bit;
      logic [7:0]                  attempts_left;
      logic [sawfr_pkg::LEN_W-1:0] byte_count;

      function new();
         failures      = 0;
         max_attempts  = sawfr_pkg::MAX_ATTEMPTS_RESET;
         sequence_bit  = 1'b0;
         attempts_left = sawfr_pkg::MAX_ATTEMPTS_RESET;
         drop_frame();
      endfunction

      function int pending();
         return awaited_rsps.size();
      endfunction

      function void set_max_attempts(logic [7:0] value);
         max_attempts = value;
      endfunction

      function void drop_frame();
         hunt        = sawfr_pkg::HS_FLAG;
         escape_seen = 1'b0;
         held_valid  = 1'b0;
         held_byte   = '0;
         running_xor = '0;
         byte_count  = '0;
      endfunction

      function void await_rsp(sawfr_pkg::out_kind_type kind, logic [7:0] data,
                              logic [7:0] ctrl, logic [sawfr_pkg::LEN_W-1:0] length);
         rsp_fields_type r;
         r.kind   = kind;
         r.data   = data;
         r.ctrl   = ctrl;
         r.length = length;
         awaited_rsps.push_back(r);
      endfunction

      // Uses up one attempt; returns 1 when none are left, and then reloads.
      function bit spend_attempt();
         if (attempts_left <= 8'd1) begin
            attempts_left = max_attempts;
            return 1'b1;
         end
         attempts_left = attempts_left - 8'd1;
         return 1'b0;
      endfunction

      // A destuffed byte pushes the one held back before it out as payload.
      function void take_byte(logic [7:0] d);
         if (held_valid) begin
            await_rsp(sawfr_pkg::KIND_PAYLOAD, held_byte, 8'h00, '0);
            running_xor = running_xor ^ held_byte;
            if (byte_count < sawfr_pkg::LEN_MAX)
               byte_count = byte_count + 1'b1;
         end
         held_byte  = d;
         held_valid = 1'b1;
      endfunction

      function void destuff(logic [7:0] b);
         if (escape_seen) begin
            escape_seen = 1'b0;
            if (b == sawfr_pkg::ESC_FLAG_BYTE)
               take_byte(sawfr_pkg::FLAG_BYTE);
            else if (b == sawfr_pkg::ESC_ESC_BYTE)
               take_byte(sawfr_pkg::ESC_BYTE);
         end else if (b == sawfr_pkg::ESC_BYTE) begin
            escape_seen = 1'b1;
         end else begin
            take_byte(b);
         end
      endfunction

      // Closing flag: the held byte is the check byte of the payload.
      function void judge_frame();
         logic [7:0] rej;
         rej = sequence_bit ? sawfr_pkg::REJ1_BYTE : sawfr_pkg::REJ0_BYTE;
         if (held_valid && held_byte == running_xor) begin
            await_rsp(sawfr_pkg::KIND_ACCEPTED, 8'h00,
                      sequence_bit ? sawfr_pkg::RR1_BYTE : sawfr_pkg::RR0_BYTE, byte_count);
            sequence_bit  = ~sequence_bit;
            attempts_left = max_attempts;
         end else if (spend_attempt()) begin
            await_rsp(sawfr_pkg::KIND_REJECTED_LAST, 8'h00, rej, byte_count);
         end else begin
            await_rsp(sawfr_pkg::KIND_REJECTED, 8'h00, rej, byte_count);
         end
         drop_frame();
      endfunction

      function void note_rx_item(sawfr_pkg::req_kind_type kind, logic [7:0] b);
         if (kind == sawfr_pkg::REQ_TIMEOUT) begin
            if (spend_attempt())
               await_rsp(sawfr_pkg::KIND_TIMEOUT_LAST, 8'h00, 8'h00, '0);
            else
               await_rsp(sawfr_pkg::KIND_TIMEOUT, 8'h00, 8'h00, '0);
            drop_frame();
            return;
         end
         case (hunt)
            sawfr_pkg::HS_FLAG: if (b == sawfr_pkg::FLAG_BYTE) hunt = sawfr_pkg::HS_ADDR;
            sawfr_pkg::HS_ADDR: if (b == sawfr_pkg::ADDR_BYTE) hunt = sawfr_pkg::HS_CTRL;
            sawfr_pkg::HS_CTRL: begin
               if (b == sawfr_pkg::CTRL_DATA_BYTE) begin
                  hunt = sawfr_pkg::HS_BCC1;
               end else if (b == sawfr_pkg::CTRL_DISC_BYTE) begin
                  await_rsp(sawfr_pkg::KIND_DISCONNECT, 8'h00, 8'h00, '0);
                  attempts_left = max_attempts;
                  drop_frame();
               end
            end
            sawfr_pkg::HS_BCC1: if (b == sawfr_pkg::BCC1_BYTE) hunt = sawfr_pkg::HS_FIRST;
            sawfr_pkg::HS_FIRST: begin
               if (b != sawfr_pkg::FLAG_BYTE) begin
                  hunt = sawfr_pkg::HS_DATA;
                  destuff(b);
               end
            end
            sawfr_pkg::HS_DATA: begin
               if (b == sawfr_pkg::FLAG_BYTE)
                  judge_frame();
               else
                  destuff(b);
            end
            default: drop_frame();
         endcase
      endfunction

      function void check_rsp(sawfr_pkg::out_kind_type kind, logic [7:0] data,
                              logic [7:0] ctrl, logic [sawfr_pkg::LEN_W-1:0] length);
         rsp_fields_type e;
         if (awaited_rsps.size() == 0) begin
            $error("unexpected response: out_kind %0d data_byte 0x%02h", kind, data);
            failures++;
            return;
         end
         e = awaited_rsps.pop_front();
         if (kind !== e.kind) begin
            $error("out_kind: expected %0d, got %0d", e.kind, kind);
            failures++;
         end
         if (data !== e.data) begin
            $error("data_byte: expected 0x%02h, got 0x%02h", e.data, data);
            failures++;
         end
         if (ctrl !== e.ctrl) begin
            $error("response_ctrl: expected 0x%02h, got 0x%02h", e.ctrl, ctrl);
            failures++;
         end
         if (length !== e.length) begin
            $error("payload_length: expected %0d, got %0d", e.length, length);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   sawfr_req_if req_bus ();
   sawfr_rsp_if rsp_bus ();
   sawfr_csr_if csr_bus ();

   stop_and_wait_frame_receiver_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   frame_verdict_board board = new();

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int unsigned send_idle   = 0;
   int unsigned rsp_stall   = 0;
   // While nonzero, the receiver holds ready low and counts this down.
   int unsigned hold_cycles = 0;
   // Request transactions completed since the current random phase began.
   int unsigned counted     = 0;
   int unsigned cycle_count = 0;

   always #5 clock = ~clock;

   // Watchdog: a run that never drains ends here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver. It stalls at random, or for a long stretch when one is requested.
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles   <= hold_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall);
      end
   end

   // Monitor. All three channels are sampled at the same rising edge. The response
   // is checked before the request of this edge is noted, since the result of that
   // request cannot appear before the next edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_rsp(rsp_bus.out_kind, rsp_bus.data_byte, rsp_bus.response_ctrl,
                            rsp_bus.payload_length);
         if (csr_bus.valid && csr_bus.ready)
            board.set_max_attempts(csr_bus.max_attempts);
         if (req_bus.valid && req_bus.ready)
            board.note_rx_item(sawfr_pkg::req_kind_type'(req_bus.req_type),
                               req_bus.rx_byte);
      end
   end

   // Offers one item and returns at the edge where its transaction completes. Valid
   // stays high afterwards, so back-to-back items need no extra assignment.
   task automatic put_item(input sawfr_pkg::req_kind_type kind, input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.rx_byte  <= b;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      counted++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      put_item(sawfr_pkg::REQ_BYTE, b);
   endtask

   // The byte field is meaningless with a timeout, so it carries random bits.
   task automatic send_timeout();
      put_item(sawfr_pkg::REQ_TIMEOUT, 8'($urandom));
   endtask

   // Stops offering items and waits until every queued result has arrived, then waits on
   // so that a stray result would still be caught.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_attempts(input logic [7:0] value);
      csr_bus.valid        <= 1'b1;
      csr_bus.max_attempts <= value;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Payload bytes lean towards the flag and escape codes so that stuffing is busy.
   function automatic logic [7:0] pick_payload_byte();
      case ($urandom_range(9))
         0: return sawfr_pkg::FLAG_BYTE;
         1: return sawfr_pkg::ESC_BYTE;
         2: return $urandom_range(1) ? sawfr_pkg::ESC_FLAG_BYTE : sawfr_pkg::ESC_ESC_BYTE;
         default: return 8'($urandom);
      endcase
   endfunction

   // Noise leans towards header bytes so that false starts happen in every hunt state.
   function automatic logic [7:0] pick_noise_byte();
      case ($urandom_range(9))
         0: return sawfr_pkg::FLAG_BYTE;
         1: return sawfr_pkg::ADDR_BYTE;
         2: return sawfr_pkg::CTRL_DATA_BYTE;
         3: return sawfr_pkg::CTRL_DISC_BYTE;
         4: return sawfr_pkg::BCC1_BYTE;
         default: return 8'($urandom);
      endcase
   endfunction

   // Sends one information frame with a stuffed payload of len bytes. With faults
   // set, the check byte is sometimes wrong, stray escape pairs are slipped in and
   // an escape may be left hanging at the closing flag.
   task automatic send_data_frame(input int unsigned len, input bit faults);
      logic [7:0] body[$];
      logic [7:0] bcc;
      logic [7:0] b;
      int unsigned k;
      bcc = 8'h00;
      for (k = 0; k < len; k++) begin
         b = pick_payload_byte();
         body.push_back(b);
         bcc ^= b;
      end
      if (faults && $urandom_range(99) < 20)
         bcc ^= 8'($urandom_range(1, 255));
      body.push_back(bcc);
      send_byte(sawfr_pkg::FLAG_BYTE);
      send_byte(sawfr_pkg::ADDR_BYTE);
      send_byte(sawfr_pkg::CTRL_DATA_BYTE);
      send_byte(sawfr_pkg::BCC1_BYTE);
      foreach (body[i]) begin
         if (faults && $urandom_range(99) < 3) begin
            // An escape followed by a byte that is not an escape code is dropped;
            // a flag here closes the frame early.
            b = 8'($urandom);
            if (b == sawfr_pkg::ESC_FLAG_BYTE || b == sawfr_pkg::ESC_ESC_BYTE)
               b = 8'h00;
            send_byte(sawfr_pkg::ESC_BYTE);
            send_byte(b);
         end
         if (body[i] == sawfr_pkg::FLAG_BYTE) begin
            send_byte(sawfr_pkg::ESC_BYTE);
            send_byte(sawfr_pkg::ESC_FLAG_BYTE);
         end else if (body[i] == sawfr_pkg::ESC_BYTE) begin
            send_byte(sawfr_pkg::ESC_BYTE);
            send_byte(sawfr_pkg::ESC_ESC_BYTE);
         end else begin
            send_byte(body[i]);
         end
      end
      if (faults && $urandom_range(99) < 4)
         send_byte(sawfr_pkg::ESC_BYTE);
      send_byte(sawfr_pkg::FLAG_BYTE);
   endtask

   // Random traffic: mostly well-formed frames with random content, the rest
   // disconnects, timeouts, broken headers and line noise.
   task automatic run_traffic(input int unsigned target);
      int unsigned pick;
      int unsigned n;
      counted = 0;
      while (counted < target) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            n = $urandom_range(99);
            if (n < 85)
               send_data_frame($urandom_range(0, 8), 1'b1);
            else
               send_data_frame($urandom_range(9, 40), 1'b1);
         end else if (pick < 62) begin
            send_byte(sawfr_pkg::FLAG_BYTE);
            send_byte(sawfr_pkg::ADDR_BYTE);
            send_byte(sawfr_pkg::CTRL_DISC_BYTE);
         end else if (pick < 72) begin
            send_timeout();
         end else if (pick < 84) begin
            // A header cut short, then either a timeout or a stray byte.
            n = $urandom_range(1, 4);
            send_byte(sawfr_pkg::FLAG_BYTE);
            if (n > 1) send_byte(sawfr_pkg::ADDR_BYTE);
            if (n > 2) send_byte(sawfr_pkg::CTRL_DATA_BYTE);
            if (n > 3) send_byte(sawfr_pkg::BCC1_BYTE);
            if ($urandom_range(1))
               send_timeout();
            else
               send_byte(pick_noise_byte());
         end else begin
            repeat ($urandom_range(1, 6))
               send_byte(pick_noise_byte());
         end
      end
   endtask

   initial begin
      logic [7:0] directed[$];

      // Every input is known from time zero, while reset is held.
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.req_type     = sawfr_pkg::REQ_BYTE;
      req_bus.rx_byte      = 8'h00;
      csr_bus.valid        = 1'b0;
      csr_bus.max_attempts = sawfr_pkg::MAX_ATTEMPTS_RESET;
      rsp_bus.ready        = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset limit of five attempts. A stray byte while
      // waiting for the flag, a flag in place of the first data byte, both escape
      // codes, an escape of the ordinary byte 0x00, and the byte 0xFF, closed
      // by a correct check byte. Then a frame whose only data is an escape still
      // pending at the closing flag, so no check byte exists, then a disconnect
      // and a timeout.
      directed = '{8'h55, sawfr_pkg::FLAG_BYTE, sawfr_pkg::ADDR_BYTE,
                   sawfr_pkg::CTRL_DATA_BYTE, sawfr_pkg::BCC1_BYTE, sawfr_pkg::FLAG_BYTE,
                   sawfr_pkg::ESC_BYTE, sawfr_pkg::ESC_FLAG_BYTE, sawfr_pkg::ESC_BYTE,
                   sawfr_pkg::ESC_ESC_BYTE, sawfr_pkg::ESC_BYTE, 8'h00,
                   8'hFF, 8'hFC, sawfr_pkg::FLAG_BYTE,
                   sawfr_pkg::FLAG_BYTE, sawfr_pkg::ADDR_BYTE, sawfr_pkg::CTRL_DATA_BYTE,
                   sawfr_pkg::BCC1_BYTE, sawfr_pkg::ESC_BYTE, sawfr_pkg::FLAG_BYTE,
                   sawfr_pkg::FLAG_BYTE, sawfr_pkg::ADDR_BYTE, sawfr_pkg::CTRL_DISC_BYTE};
      foreach (directed[i])
         send_byte(directed[i]);
      send_timeout();
      drain();

      // No idling, a single attempt per frame. A payload longer than the maximum
      // checks that the length saturates. Midway the receiver holds off for a long
      // stretch while items keep coming, so the block fills up and stalls its input.
      write_max_attempts(8'd1);
      send_data_frame(1030, 1'b0);
      run_traffic(100);
      hold_cycles <= 400;
      run_traffic(60);
      drain();

      // Sender idles often; the largest attempt limit. Halfway the sender waits
      // until every outstanding result has come back.
      write_max_attempts(8'd255);
      send_idle = 64;
      run_traffic(90);
      drain();
      run_traffic(80);
      drain();

      // Receiver stalls often, with a random limit and one more long hold-off.
      write_max_attempts(8'($urandom_range(2, 254)));
      send_idle = 0;
      rsp_stall = 64;
      run_traffic(70);
      hold_cycles <= 250;
      run_traffic(90);
      drain();

      // Both sides idle now and then.
      write_max_attempts(8'd3);
      send_idle = 18;
      rsp_stall = 18;
      run_traffic(150);
      drain();

      if (board.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/sawfr_pkg.sv
rtl/core/sawfr_ifs.sv
rtl/core/sawfr_step.sv
rtl/core/stop_and_wait_frame_receiver_core.sv
verif/tb.sv
